// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_sig, rstn_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
		else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk_sig, rstn_sig, prop)
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons)
`endif
`endif

// ===== rtl/exs_pkg.sv =====
// Package of the exchange sorter: constants and the queue entry type.
`timescale 1ns / 1ps
package exs_pkg;
	localparam int EXS_BATCH_SIZE  = 4;
	localparam int EXS_QUEUE_DEPTH = 4;
	localparam int DATA_W          = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;   // item completes a batch
		logic                     desc;   // direction sampled when the item is pushed
	} qent_t;
endpackage

// ===== rtl/exchange_sorter_with_direction.sv =====
// Top level of the exchange sorter with selectable direction.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// - Input stream s_*: one signed 32-bit value per item. Every BATCH_SIZE items
//   form a batch.
// - Output stream m_*: the batch comes out sorted, BATCH_SIZE items, with
//   m_tlast high on the final one.
// - cfg_wr_en / cfg_wr_data: direction register, 0 ascending, 1 descending.
//   The value held when the closing item of a batch is accepted applies.
// - The front end takes an item per cycle while the 4-entry queue has room.
// - The back end loads one item per cycle from the queue while it is not
//   empty, then sorts in a batch memory with one read and one write port:
//   per outer position one read, one compare per later position, one
//   write back. Each item is emitted by a memory read, then an output load.
// - Output is a register: a stalled m_tready holds the item and the sequencer,
//   while the front end keeps filling the queue until it is full.
// - Reset (arst_n low) empties the queue, clears the batch position and sets
//   ascending order; memory contents are not cleared.
module exchange_sorter_with_direction import exs_pkg::*; #(
	parameter int BATCH_SIZE = EXS_BATCH_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] element_value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic              m_tlast,   // last_of_batch
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data // sort_descending
);
	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	qent_t q_wdata;
	qent_t q_rdata;

	// front end: batch position and direction tagging
	exs_front #(.BATCH_SIZE(BATCH_SIZE)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	// decoupling queue
	exs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back end: load, sort, emit
	exs_back #(.BATCH_SIZE(BATCH_SIZE)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// back end never pops an empty queue
	`ASSERT_ALWAYS(a_pop_nonempty, clk, arst_n, !(q_pop && q_empty))
	// after the closing item leaves, the next batch must still be loaded and sorted
	`ASSERT_NEXT(a_gap_after_last, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)
endmodule

// ===== rtl/exs_front.sv =====
// Front end: accepts items, tracks batch position, holds the direction, tags the closing item.
`timescale 1ns / 1ps
module exs_front import exs_pkg::*; #(
	parameter int BATCH_SIZE = EXS_BATCH_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              q_full,
	output logic              q_push,
	output qent_t             q_wdata
);
	localparam int IDX_W = $clog2(BATCH_SIZE);

	logic [IDX_W-1:0] fill_q;
	logic             desc_q;
	logic             is_last;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign is_last  = (fill_q == IDX_W'(BATCH_SIZE - 1));

	assign q_wdata.value = $signed(s_tdata);
	assign q_wdata.last  = is_last;
	assign q_wdata.desc  = desc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			desc_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				desc_q <= cfg_wr_data;
			end
			if (q_push) begin
				fill_q <= is_last ? '0 : fill_q + 1'b1;
			end
		end
	end
endmodule

// ===== rtl/exs_queue.sv =====
// Short FIFO between front and back ends.
`timescale 1ns / 1ps
module exs_queue import exs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wdata,
	input  logic  pop,
	output qent_t rdata,
	output logic  full,
	output logic  empty
);
	localparam int PTR_W = $clog2(EXS_QUEUE_DEPTH);
	localparam int CNT_W = $clog2(EXS_QUEUE_DEPTH + 1);

	qent_t            slot_q [EXS_QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(EXS_QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(EXS_QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(EXS_QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== rtl/exs_back.sv =====
// Back end: batch memory, exchange-sort sequencer and output register.
`timescale 1ns / 1ps
module exs_back import exs_pkg::*; #(
	parameter int BATCH_SIZE = EXS_BATCH_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  qent_t             q_rdata,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast
);
	localparam int IDX_W = $clog2(BATCH_SIZE);
	localparam int CNT_W = $clog2(BATCH_SIZE + 1);

	typedef enum logic [6:0] {
		ST_LOAD    = 7'b0000001,
		ST_SORT_I  = 7'b0000010,
		ST_SORT_LD = 7'b0000100,
		ST_SORT_J  = 7'b0001000,
		ST_SORT_WB = 7'b0010000,
		ST_EMIT_RD = 7'b0100000,
		ST_EMIT_WR = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [DATA_W-1:0]        batch_mem [BATCH_SIZE];
	logic [DATA_W-1:0]        rd_q;
	logic signed [DATA_W-1:0] cur_q;
	logic [IDX_W-1:0]         ld_q;
	logic [IDX_W-1:0]         i_q;
	logic [IDX_W-1:0]         jp_q;
	logic [CNT_W-1:0]         j_q;
	logic [IDX_W-1:0]         k_q;
	logic                     desc_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_data_q;
	logic                     out_last_q;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              do_swap;
	logic              out_free;
	logic              j_more;
	logic              emit_fire;

	assign out_free  = !out_valid_q || m_tready;
	assign emit_fire = (state_q == ST_EMIT_WR) && out_free;
	assign j_more    = (j_q < CNT_W'(BATCH_SIZE));
	// ascending: swap when held value is above the probe; descending the reverse
	assign do_swap   = desc_q ? ($signed(rd_q) > cur_q) : (cur_q > $signed(rd_q));
	assign q_pop     = (state_q == ST_LOAD) && !q_empty;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = cur_q;
		rd_en   = 1'b0;
		rd_addr = i_q;
		unique case (state_q)
			ST_LOAD: begin
				wr_en   = q_pop;
				wr_addr = ld_q;
				wr_data = q_rdata.value;
			end
			ST_SORT_I: begin
				rd_en = 1'b1;
			end
			ST_SORT_LD: begin
				rd_en   = 1'b1;
				rd_addr = j_q[IDX_W-1:0];
			end
			ST_SORT_J: begin
				wr_en   = do_swap;
				wr_addr = jp_q;
				rd_en   = j_more;
				rd_addr = j_q[IDX_W-1:0];
			end
			ST_SORT_WB: begin
				wr_en = 1'b1;
			end
			ST_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
			end
			ST_EMIT_WR: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			batch_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= batch_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SORT_LD) begin
			cur_q <= $signed(rd_q);
		end else if (state_q == ST_SORT_J && do_swap) begin
			cur_q <= $signed(rd_q);
		end
		if (emit_fire) begin
			out_data_q <= rd_q;
			out_last_q <= (k_q == IDX_W'(BATCH_SIZE - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			ld_q        <= '0;
			i_q         <= '0;
			jp_q        <= '0;
			j_q         <= '0;
			k_q         <= '0;
			desc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (q_rdata.last) begin
							ld_q    <= '0;
							i_q     <= '0;
							desc_q  <= q_rdata.desc;
							state_q <= ST_SORT_I;
						end else begin
							ld_q <= ld_q + 1'b1;
						end
					end
				end
				ST_SORT_I: begin
					j_q     <= CNT_W'(i_q) + 1'b1;
					state_q <= ST_SORT_LD;
				end
				ST_SORT_LD: begin
					jp_q    <= j_q[IDX_W-1:0];
					j_q     <= j_q + 1'b1;
					state_q <= ST_SORT_J;
				end
				ST_SORT_J: begin
					if (j_more) begin
						jp_q <= j_q[IDX_W-1:0];
						j_q  <= j_q + 1'b1;
					end else begin
						state_q <= ST_SORT_WB;
					end
				end
				ST_SORT_WB: begin
					if (i_q == IDX_W'(BATCH_SIZE - 2)) begin
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SORT_I;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						if (k_q == IDX_W'(BATCH_SIZE - 1)) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
endmodule
